>>> design/mv_difference_binarizer_core_macros.svh
// assertion macros for the motion vector difference binarizer
// used by modules that check their own control logic; needs clk and rst in scope
`ifndef MV_DIFFERENCE_BINARIZER_CORE_MACROS_SVH
`define MV_DIFFERENCE_BINARIZER_CORE_MACROS_SVH

// same-cycle implication
`define MVDB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MVDB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mvdb_pkg.sv
// types, constants and decision functions of the motion vector difference binarizer
// no dependencies
package mvdb_pkg;

  localparam logic [7:0] SHORT_MAX    = 8'd7;
  localparam logic [7:0] LONG_HI_MASK = 8'hF0;
  localparam logic [7:0] MAG_SAT      = 8'hFF;

  localparam logic [4:0] SLOT_IS_SHORT = 5'd0;
  localparam logic [4:0] SLOT_SIGN     = 5'd1;
  localparam logic [4:0] SLOT_TREE     = 5'd2;
  localparam logic [4:0] SLOT_LONG     = 5'd9;

  localparam logic [3:0] CNT_SHORT_ZERO = 4'd4;
  localparam logic [3:0] CNT_SHORT      = 4'd5;
  localparam logic [3:0] CNT_LONG_LO    = 4'd9;
  localparam logic [3:0] CNT_LONG       = 4'd10;

  // magnitude bit order of the long form after the is-short decision
  localparam logic [2:0] LONG_ORDER [7] = '{3'd0, 3'd1, 3'd2, 3'd7, 3'd6, 3'd5, 3'd4};

  typedef struct packed {
    logic [7:0] mag;
    logic       sign;
    logic       clamp;
  } mvdb_comp_t;

  typedef struct packed {
    mvdb_comp_t y;
    mvdb_comp_t x;
  } mvdb_vec_t;

  typedef struct packed {
    logic       value;
    logic [4:0] slot;
  } mvdb_dec_t;

  typedef struct packed {
    logic       decision_bit;
    logic       component;
    logic [4:0] prob_slot;
    logic       clamped;
    logic       last;
  } mvdb_word_t;

  function automatic logic [3:0] mvdb_count(input logic [7:0] mag);
    logic [3:0] cnt;
    if (mag <= SHORT_MAX) begin
      cnt = (mag == 8'd0) ? CNT_SHORT_ZERO : CNT_SHORT;
    end else begin
      cnt = ((mag & LONG_HI_MASK) != 8'd0) ? CNT_LONG : CNT_LONG_LO;
    end
    return cnt;
  endfunction

  function automatic mvdb_dec_t mvdb_decide(input logic [7:0] mag, input logic sign,
                                            input logic [3:0] step);
    mvdb_dec_t  r;
    logic [2:0] node;
    logic [2:0] bidx;
    r.value = sign;
    r.slot  = SLOT_SIGN;
    node    = 3'd0;
    bidx    = 3'd0;
    if (mag <= SHORT_MAX) begin
      case (step)
        4'd0: begin
          r.value = 1'b0;
          r.slot  = SLOT_IS_SHORT;
        end
        4'd1: begin
          r.value = mag[2];
          r.slot  = SLOT_TREE;
        end
        4'd2: begin
          node    = mag[2] ? 3'd4 : 3'd1;
          r.value = mag[1];
          r.slot  = SLOT_TREE + {2'b00, node};
        end
        4'd3: begin
          node    = mag[2] ? (mag[1] ? 3'd6 : 3'd5) : (mag[1] ? 3'd3 : 3'd2);
          r.value = mag[0];
          r.slot  = SLOT_TREE + {2'b00, node};
        end
        default: begin
          r.value = sign;
          r.slot  = SLOT_SIGN;
        end
      endcase
    end else begin
      case (step) inside
        4'd0: begin
          r.value = 1'b1;
          r.slot  = SLOT_IS_SHORT;
        end
        [4'd1:4'd7]: begin
          bidx    = LONG_ORDER[3'(step - 4'd1)];
          r.value = mag[bidx];
          r.slot  = SLOT_LONG + {2'b00, bidx};
        end
        4'd8: begin
          if ((mag & LONG_HI_MASK) != 8'd0) begin
            r.value = mag[3];
            r.slot  = SLOT_LONG + 5'd3;
          end
        end
        default: begin
          r.value = sign;
          r.slot  = SLOT_SIGN;
        end
      endcase
    end
    return r;
  endfunction

endpackage

>>> design/mvdb_emitter.sv
// decision sequencer and output register: walks both components of a vector,
// one decision word per cycle while the output is accepted; depends on mvdb_pkg and the assertion macros
`include "mv_difference_binarizer_core_macros.svh"

module mvdb_emitter
  import mvdb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mvdb_vec_t  in_vec,
  output logic       out_valid,
  input  logic       out_ready,
  output mvdb_word_t out_word
);

  logic       busy;
  logic       comp;
  logic [3:0] step;
  mvdb_vec_t  vec;

  mvdb_comp_t cur;
  logic [3:0] cnt;
  logic       last_dec;
  logic       fire;
  mvdb_dec_t  dec;

  always_comb begin
    cur      = comp ? vec.y : vec.x;
    cnt      = mvdb_count(cur.mag);
    last_dec = (step == cnt - 4'd1);
    fire     = busy && (!out_valid || out_ready);
    in_ready = !busy || (fire && last_dec && comp);
    dec      = mvdb_decide(cur.mag, cur.sign, step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      comp      <= 1'b0;
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        out_valid             <= 1'b1;
        out_word.decision_bit <= dec.value;
        out_word.component    <= comp;
        out_word.prob_slot    <= dec.slot;
        out_word.clamped      <= cur.clamp;
        out_word.last         <= last_dec && comp;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        busy <= 1'b1;
        comp <= 1'b0;
        step <= 4'd0;
        vec  <= in_vec;
      end else if (fire) begin
        if (last_dec) begin
          step <= 4'd0;
          if (comp) begin
            busy <= 1'b0;
          end else begin
            comp <= 1'b1;
          end
        end else begin
          step <= step + 4'd1;
        end
      end
    end
  end

  `MVDB_ASSERT_NOW(a_step_range, busy, step < cnt, "step beyond decision count")
  `MVDB_ASSERT_NEXT(a_load_start, in_valid && in_ready, busy && !comp && step == 4'd0, "load did not restart sequence")
  `MVDB_ASSERT_NOW(a_last_on_y, out_valid && out_word.last, out_word.component, "last on horizontal word")
  `MVDB_ASSERT_NEXT(a_fire_word, fire, out_valid, "issued decision not presented")

endmodule

>>> design/mv_difference_binarizer_core.sv
// top level of the motion vector difference binarizer
// predictor select and difference, magnitude/clamp stage, then mvdb_emitter; uses mvdb_pkg
//
// usage:
//   slave stream s_* takes one motion vector with its two predictors per word;
//   master stream m_* gives one binary decision per word, tagged with component,
//   probability slot and clamp flag; m_tlast marks the vector's final decision.
//   path: the first decision of a vector passes the difference register, the
//   magnitude/clamp register, the sequencer's vector register and its output register.
//   throughput: one decision word per cycle while m_tready is high; a vector gives
//   8 to 20 words, set by its decision count in the emitter sequencer (4, 5, 9 or 10 per
//   component). the two front stages take the next vectors meanwhile.
//   stall: when m_tready is low the output word holds; the sequencer and the
//   front stages stop and s_tready falls once every stage is full. nothing is
//   dropped or repeated.
//   reset: rst (synchronous) empties all stages; m_tvalid is low afterwards and
//   s_tready is high in the cycle after reset.
module mv_difference_binarizer_core
  import mvdb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mv_x[8:0] mv_y[17:9] inter_pred_valid[18] inter_pred_x[27:19]
  // inter_pred_y[36:28] gold_pred_valid[37] gold_pred_x[46:38] gold_pred_y[55:47]
  input  logic [55:0] s_tdata,
  // mode_is_golden[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // decision_bit[0], zero fill above
  output logic [7:0]  m_tdata,
  // component[0] prob_slot[5:1] clamped[6]
  output logic [6:0]  m_tuser,
  output logic        m_tlast
);

  logic [8:0] mv_x, mv_y, ip_x, ip_y, gp_x, gp_y, px, py;
  logic       ip_valid, gp_valid;

  logic       s1_valid;
  logic [9:0] s1_dx, s1_dy;
  logic       s2_valid;
  logic       s2_ready;
  mvdb_vec_t  s2_vec;
  mvdb_vec_t  s2_vec_next;
  logic       em_ready;
  mvdb_word_t word;

  logic [9:0] abs_x, abs_y;

  always_comb begin
    mv_x     = s_tdata[8:0];
    mv_y     = s_tdata[17:9];
    ip_valid = s_tdata[18];
    ip_x     = s_tdata[27:19];
    ip_y     = s_tdata[36:28];
    gp_valid = s_tdata[37];
    gp_x     = s_tdata[46:38];
    gp_y     = s_tdata[55:47];
    if (s_tuser) begin
      px = gp_valid ? gp_x : 9'd0;
      py = gp_valid ? gp_y : 9'd0;
    end else begin
      px = ip_valid ? ip_x : 9'd0;
      py = ip_valid ? ip_y : 9'd0;
    end
  end

  assign s2_ready = !s2_valid || em_ready;
  assign s_tready = !s1_valid || s2_ready;

  always_comb begin
    abs_x                = s1_dx[9] ? (10'd0 - s1_dx) : s1_dx;
    abs_y                = s1_dy[9] ? (10'd0 - s1_dy) : s1_dy;
    s2_vec_next.x.sign   = s1_dx[9];
    s2_vec_next.x.clamp  = (abs_x[9:8] != 2'b00);
    s2_vec_next.x.mag    = s2_vec_next.x.clamp ? MAG_SAT : abs_x[7:0];
    s2_vec_next.y.sign   = s1_dy[9];
    s2_vec_next.y.clamp  = (abs_y[9:8] != 2'b00);
    s2_vec_next.y.mag    = s2_vec_next.y.clamp ? MAG_SAT : abs_y[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
        s1_dx    <= {mv_x[8], mv_x} - {px[8], px};
        s1_dy    <= {mv_y[8], mv_y} - {py[8], py};
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
        s2_vec   <= s2_vec_next;
      end
    end
  end

  mvdb_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (em_ready),
    .in_vec    (s2_vec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (word)
  );

  assign m_tdata = {7'd0, word.decision_bit};
  assign m_tuser = {word.clamped, word.prob_slot, word.component};
  assign m_tlast = word.last;

endmodule

>>> verif/tb_mv_difference_binarizer_core.sv
// testbench for mv_difference_binarizer_core: random and directed vectors against a decision predictor
// needs mvdb_pkg and the rtl of the core; stands alone otherwise
`timescale 1ns / 100ps

module tb_mv_difference_binarizer_core
  import mvdb_pkg::*;
();

  class decision_scoreboard;
    mvdb_word_t expected_decisions[$];
    int         mismatches = 0;

    function void queue_decision(logic value, logic comp, logic [4:0] slot, logic clip);
      mvdb_word_t w;
      w.decision_bit = value;
      w.component    = comp;
      w.prob_slot    = slot;
      w.clamped      = clip;
      w.last         = 1'b0;
      expected_decisions.push_back(w);
    endfunction

    function void code_axis(logic comp, int vec, int pred);
      int          diff;
      int          m;
      logic        neg;
      logic        clip;
      logic [7:0]  mag;
      logic [2:0]  node;
      int unsigned bit_order[7] = '{0, 1, 2, 7, 6, 5, 4};
      diff = vec - pred;
      neg  = (diff < 0);
      m    = neg ? -diff : diff;
      clip = (m > 255);
      if (clip) begin
        m = 255;
      end
      mag = m[7:0];
      if (mag <= SHORT_MAX) begin
        queue_decision(1'b0, comp, SLOT_IS_SHORT, clip);
        queue_decision(mag[2], comp, SLOT_TREE, clip);
        node = mag[2] ? 3'd4 : 3'd1;
        queue_decision(mag[1], comp, SLOT_TREE + {2'b00, node}, clip);
        node = mag[2] ? (mag[1] ? 3'd6 : 3'd5) : (mag[1] ? 3'd3 : 3'd2);
        queue_decision(mag[0], comp, SLOT_TREE + {2'b00, node}, clip);
        if (mag != 8'd0) begin
          queue_decision(neg, comp, SLOT_SIGN, clip);
        end
      end else begin
        queue_decision(1'b1, comp, SLOT_IS_SHORT, clip);
        foreach (bit_order[k]) begin
          queue_decision(mag[bit_order[k]], comp, SLOT_LONG + 5'(bit_order[k]), clip);
        end
        if ((mag & LONG_HI_MASK) != 8'd0) begin
          queue_decision(mag[3], comp, SLOT_LONG + 5'd3, clip);
        end
        queue_decision(neg, comp, SLOT_SIGN, clip);
      end
    endfunction

    function void add_vector(logic [55:0] word, logic golden);
      int px;
      int py;
      px = 0;
      py = 0;
      if (!golden && word[18]) begin
        px = $signed(word[27:19]);
        py = $signed(word[36:28]);
      end else if (golden && word[37]) begin
        px = $signed(word[46:38]);
        py = $signed(word[55:47]);
      end
      code_axis(1'b0, $signed(word[8:0]), px);
      code_axis(1'b1, $signed(word[17:9]), py);
      expected_decisions[expected_decisions.size() - 1].last = 1'b1;
    endfunction

    function void check_decision(mvdb_word_t got);
      mvdb_word_t exp_w;
      if (expected_decisions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: bit %b comp %b slot %0d clamp %b last %b",
                   got.decision_bit, got.component, got.prob_slot, got.clamped, got.last);
        end
      end else begin
        exp_w = expected_decisions.pop_front();
        if (got.decision_bit !== exp_w.decision_bit || got.component !== exp_w.component ||
            got.prob_slot !== exp_w.prob_slot || got.clamped !== exp_w.clamped ||
            got.last !== exp_w.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected bit %b comp %b slot %0d clamp %b last %b",
                     exp_w.decision_bit, exp_w.component, exp_w.prob_slot, exp_w.clamped,
                     exp_w.last);
            $display("          actual   bit %b comp %b slot %0d clamp %b last %b",
                     got.decision_bit, got.component, got.prob_slot, got.clamped, got.last);
          end
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic [6:0]  m_tuser;
  logic        m_tlast;

  decision_scoreboard sb = new;
  bit                 steady = 1'b0;

  mv_difference_binarizer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    mvdb_word_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.decision_bit = m_tdata[0];
      got.component    = m_tuser[0];
      got.prob_slot    = m_tuser[5:1];
      got.clamped      = m_tuser[6];
      got.last         = m_tlast;
      sb.check_decision(got);
    end
    m_tready <= steady || ($urandom_range(99) >= 24);
  end

  function automatic logic [55:0] pack_vector(int mvx, int mvy, logic ipv, int ipx, int ipy,
                                              logic gpv, int gpx, int gpy);
    return {gpy[8:0], gpx[8:0], gpv, ipy[8:0], ipx[8:0], ipv, mvy[8:0], mvx[8:0]};
  endfunction

  function automatic int rand_s9();
    return int'($urandom_range(511)) - 256;
  endfunction

  // component value for a difference of a random class against pred
  function automatic int pick_component(int pred);
    int d;
    case ($urandom_range(4))
      0: d = int'($urandom_range(14)) - 7;
      1: d = int'($urandom_range(510)) - 255;
      2: d = int'($urandom_range(511, 256));
      3: d = int'($urandom_range(255, 8));
      default: return rand_s9();
    endcase
    if ($urandom_range(1) && d != 0) begin
      d = -d;
    end
    if (d > 255 - pred) begin
      d = 255 - pred;
    end
    if (d < -256 - pred) begin
      d = -256 - pred;
    end
    return pred + d;
  endfunction

  task automatic send_vector(logic [55:0] word, logic golden);
    while (!steady && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= golden;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    sb.add_vector(word, golden);
  endtask

  task automatic send_random_vector();
    logic golden;
    logic ipv;
    logic gpv;
    int   ipx;
    int   ipy;
    int   gpx;
    int   gpy;
    int   px;
    int   py;
    golden = $urandom_range(1);
    ipv    = ($urandom_range(3) != 0);
    gpv    = ($urandom_range(3) != 0);
    ipx    = rand_s9();
    ipy    = rand_s9();
    gpx    = rand_s9();
    gpy    = rand_s9();
    px     = golden ? (gpv ? gpx : 0) : (ipv ? ipx : 0);
    py     = golden ? (gpv ? gpy : 0) : (ipv ? ipy : 0);
    send_vector(pack_vector(pick_component(px), pick_component(py), ipv, ipx, ipy,
                            gpv, gpx, gpy), golden);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero vector, then every short magnitude in both signs
    send_vector(pack_vector(0, 0, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    for (int k = 1; k <= 7; k++) begin
      send_vector(pack_vector(k, -k, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    end
    // long form with and without bit 3, boundary magnitudes
    send_vector(pack_vector(8, -15, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    send_vector(pack_vector(16, -128, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    send_vector(pack_vector(255, -255, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    send_vector(pack_vector(7, 8, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    // clamped differences
    send_vector(pack_vector(-256, -256, 1'b0, 0, 0, 1'b0, 0, 0), 1'b0);
    send_vector(pack_vector(255, -256, 1'b1, -256, 255, 1'b0, 0, 0), 1'b0);
    send_vector(pack_vector(-256, 255, 1'b0, 0, 0, 1'b1, 255, -256), 1'b1);
    // predictor selection, invalid and unused predictors
    send_vector(pack_vector(10, -3, 1'b1, -256, 255, 1'b1, 3, 4), 1'b1);
    send_vector(pack_vector(-5, 200, 1'b1, 50, 60, 1'b0, 100, -100), 1'b1);
    send_vector(pack_vector(0, 0, 1'b0, 30, -30, 1'b1, -256, 255), 1'b0);
    send_vector(pack_vector(0, 0, 1'b1, 0, 0, 1'b1, -256, 255), 1'b0);
    send_vector(pack_vector(-1, -1, 1'b1, -1, -1, 1'b1, -1, -1), 1'b1);
    send_vector(pack_vector(255, 255, 1'b1, 255, 255, 1'b1, 255, 255), 1'b0);
    send_vector(pack_vector(-100, 77, 1'b0, 255, 255, 1'b1, -200, 70), 1'b1);

    for (int n = 0; n < 130; n++) begin
      steady = (n >= 50 && n < 90);
      send_random_vector();
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.expected_decisions.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_decisions.size() == 0) begin
      $display("mv_difference_binarizer_core test passed");
    end else begin
      $display("mv_difference_binarizer_core test failed");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("mv_difference_binarizer_core test failed");
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/mvdb_pkg.sv
design/mvdb_emitter.sv
design/mv_difference_binarizer_core.sv
verif/tb_mv_difference_binarizer_core.sv
